### rtl/cwss_pkg.sv
`default_nettype none
package cwss_pkg;
	localparam int MAX_ITEMS = 1024;
	localparam int VAL_W     = 16;
	localparam int SUM_W     = 26;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = IDX_W + 1;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
endpackage
`default_nettype wire

### rtl/cwss_if.sv
`default_nettype none
// Item channel: one sequence element per transaction.
interface cwss_in_if;
	import cwss_pkg::*;
	logic valid;
	logic ready;
	val_t value;
	logic last_item;
	modport source (output valid, output value, output last_item, input ready);
	modport sink   (input valid, input value, input last_item, output ready);
endinterface

// Result channel: best window indices.
interface cwss_res_if;
	import cwss_pkg::*;
	logic valid;
	logic ready;
	idx_t window_start;
	idx_t window_end;
	modport source (output valid, output window_start, output window_end, input ready);
	modport sink   (input valid, input window_start, input window_end, output ready);
endinterface

// Target register write channel.
interface cwss_cfg_if;
	import cwss_pkg::*;
	logic valid;
	logic ready;
	sum_t target_sum;
	modport source (output valid, output target_sum, input ready);
	modport sink   (input valid, input target_sum, output ready);
endinterface
`default_nettype wire

### rtl/closest_window_sum_search.sv
`default_nettype none
// Closest window sum search.
// in_ch  : one element per transaction (value, last_item). Each element is
//          stored as a prefix sum; in_ch.ready is high only in the idle state,
//          so it is low while a search runs or a result waits in DONE.
// cfg_ch : writes target_sum; always ready, write only while the block is idle.
// res_ch : one transaction per sequence, after the element marked last,
//          giving window_start/window_end (zero-based) of the closest window.
// Walk   : the two-pointer walk runs on one shared subtract/compare unit.
//          A window step runs through read prefix memory, subtract,
//          distance and compare/advance; skipping an empty window is
//          done in the read state alone. With n elements there are at
//          most about 2n steps. The four-state step sequence on the
//          shared unit sets the per-step pace.
// Stall  : the result sits in an output register; loading of the next
//          sequence goes on meanwhile. A following search that finishes
//          before the old result is taken waits in DONE until it is.
// Reset  : clears target, counters and pointers. The prefix memory needs no
//          clearing: the walk only reads entries written for this sequence.
module closest_window_sum_search (
	input  wire        clk,
	input  wire        arst_n,
	cwss_in_if.sink    in_ch,
	cwss_cfg_if.sink   cfg_ch,
	cwss_res_if.source res_ch
);
	import cwss_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_SUB  = 3'd2;
	localparam logic [2:0] ST_DIST = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	sum_t       target_q;
	sum_t       run_sum_q;
	cnt_t       count_q;      // element count, also n during the walk
	cnt_t       left_q;       // one-based window ends
	cnt_t       right_q;
	sum_t       best_dist_q;
	idx_t       best_left_q;  // zero-based
	idx_t       best_right_q;
	sum_t       win_q;
	sum_t       dist_q;
	logic       lt_q;
	logic       gt_q;
	logic       res_valid_q;
	idx_t       res_start_q;
	idx_t       res_end_q;

	// prefix memory: entry m holds the sum of elements 0..m
	sum_t       mem [MAX_ITEMS];
	sum_t       rd_right_q;
	sum_t       rd_left_q;

	logic       in_take;
	logic       store_ok;
	sum_t       sum_next;
	idx_t       addr_right;
	idx_t       addr_left;
	cnt_t       right_inc;
	cnt_t       left_inc;
	logic       left_is_one;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign in_take      = in_ch.valid && in_ch.ready;
	assign store_ok     = (count_q < cnt_t'(MAX_ITEMS));
	assign sum_next     = run_sum_q + sum_t'(in_ch.value);

	assign right_inc    = right_q + cnt_t'(1);
	assign left_inc     = left_q + cnt_t'(1);
	assign left_is_one  = (left_q == cnt_t'(1));
	// prefix(r) lives at r-1, prefix(l-1) at l-2 (zero when l is one)
	assign addr_right   = idx_t'(right_q - cnt_t'(1));
	assign addr_left    = idx_t'(left_q - cnt_t'(2));

	assign res_ch.valid        = res_valid_q;
	assign res_ch.window_start = res_start_q;
	assign res_ch.window_end   = res_end_q;

	always_ff @(posedge clk) begin
		if (in_take && store_ok) begin
			mem[count_q[IDX_W-1:0]] <= sum_next;
		end
		rd_right_q <= mem[addr_right];
		rd_left_q  <= mem[addr_left];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			target_q <= cfg_ch.target_sum;
		end
	end

	// shared datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SUB: begin
				win_q <= rd_right_q - (left_is_one ? '0 : rd_left_q);
			end
			ST_DIST: begin
				dist_q <= (win_q >= target_q) ? (win_q - target_q) : (target_q - win_q);
				lt_q   <= (win_q < target_q);
				gt_q   <= (win_q > target_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			run_sum_q    <= '0;
			count_q      <= '0;
			left_q       <= cnt_t'(1);
			right_q      <= cnt_t'(1);
			best_dist_q  <= '1;
			best_left_q  <= '0;
			best_right_q <= '0;
			res_valid_q  <= 1'b0;
			res_start_q  <= '0;
			res_end_q    <= '0;
		end else begin
			if (res_valid_q && res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (store_ok) begin
							run_sum_q <= sum_next;
							count_q   <= count_q + cnt_t'(1);
						end
						if (in_ch.last_item) begin
							left_q       <= cnt_t'(1);
							right_q      <= cnt_t'(1);
							best_dist_q  <= '1;
							best_left_q  <= '0;
							best_right_q <= '0;
							state_q      <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (left_q > count_q) begin
						state_q <= ST_DONE;
					end else if (left_q > right_q) begin
						// empty window: advance right end only
						right_q <= right_inc;
						if (right_inc > count_q) begin
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					state_q <= ST_DIST;
				end
				ST_DIST: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (best_dist_q > dist_q) begin
						best_dist_q  <= dist_q;
						best_left_q  <= idx_t'(left_q - cnt_t'(1));
						best_right_q <= idx_t'(right_q - cnt_t'(1));
					end
					priority if (lt_q) begin
						right_q <= right_inc;
						state_q <= (right_inc > count_q) ? ST_DONE : ST_RD;
					end else if (gt_q) begin
						left_q  <= left_inc;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_DONE; // exact match
					end
				end
				ST_DONE: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						res_start_q <= best_left_q;
						res_end_q   <= best_right_q;
						run_sum_q   <= '0;
						count_q     <= '0;
						left_q      <= cnt_t'(1);
						right_q     <= cnt_t'(1);
						best_dist_q <= '1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### verif/tb_closest_window_sum_search.sv
`timescale 1ns / 1ps

// Testbench for the closest window sum search.
// Elements are queued by the stimulus process and handed to the block by a
// clocked driver. The monitor keeps a mirror of the prefix sums and redoes
// the two-pointer walk at every accepted last element. It then checks each
// result transaction against the oldest predicted window.
module tb_closest_window_sum_search;
	import cwss_pkg::*;

	localparam sum_t SUM_MAX       = '1;
	localparam int   SETTLE_CYCLES = 32;    // pause after the last result
	localparam int   HOLD_CYCLES   = 400;   // long result back-pressure
	localparam int   PHASES        = 24;
	localparam int   PHASE_ITEMS   = 35;
	localparam int   BIG_PHASE     = 20;    // phase with the over-full set
	localparam int   HOLD_PHASE    = 17;
	localparam int   BIG_LEN       = MAX_ITEMS + 2;

	typedef struct packed {
		val_t value;
		logic ends_set;
	} elem_t;

	typedef struct packed {
		idx_t start_idx;
		idx_t end_idx;
	} window_t;

	// Every block input has a known value from time zero. Declaration
	// initialisers feed the interfaces through continuous assigns.
	logic clk        = 1'b0;
	logic arst_n     = 1'b0;
	logic in_valid   = 1'b0;
	val_t in_value   = '0;
	logic in_last    = 1'b0;
	logic cfg_valid  = 1'b0;
	sum_t cfg_target = '0;
	logic res_rdy    = 1'b0;

	cwss_in_if  in_ch ();
	cwss_cfg_if cfg_ch ();
	cwss_res_if res_ch ();

	assign in_ch.valid       = in_valid;
	assign in_ch.value       = in_value;
	assign in_ch.last_item   = in_last;
	assign cfg_ch.valid      = cfg_valid;
	assign cfg_ch.target_sum = cfg_target;
	assign res_ch.ready      = res_rdy;

	closest_window_sum_search u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg_ch (cfg_ch),
		.res_ch (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Elements waiting for their transaction, and windows still owed by the block.
	elem_t   elem_q[$];
	window_t window_q[$];

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_asks     = 0;    // bumped by stimulus to request a long hold-off
	int   err_cnt       = 0;
	logic item_taken    = 1'b0;

	// Mirror of the block's state.
	sum_t target_mirror = '0;
	sum_t run_total     = '0;
	int   elem_cnt      = 0;
	sum_t prefix_mem [MAX_ITEMS];

	// Sum of the first m elements; m = 0 gives the empty prefix.
	function automatic sum_t prefix_upto(input int m);
		return (m == 0) ? sum_t'(0) : prefix_mem[m-1];
	endfunction

	function automatic sum_t sum_gap(input sum_t a, input sum_t b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Two-pointer walk over the loaded set, one-based window ends.
	// Strict compare keeps the first window on a tie. A window with its left
	// end past the right is empty: skipped, and the right end moves on.
	function automatic window_t closest_window();
		int      n, lo, hi, best_lo, best_hi;
		sum_t    win, gap, best_gap;
		window_t w;
		n        = elem_cnt;
		best_gap = sum_gap(prefix_mem[0], target_mirror);
		best_lo  = 1;
		best_hi  = 1;
		lo       = 1;
		hi       = 1;
		while (lo <= n) begin
			if (lo > hi) begin
				hi++;
				if (hi > n)
					break;
				continue;
			end
			win = prefix_upto(hi) - prefix_upto(lo - 1);
			gap = sum_gap(win, target_mirror);
			if (best_gap > gap) begin
				best_gap = gap;
				best_lo  = lo;
				best_hi  = hi;
			end
			if (win < target_mirror) begin
				hi++;
				if (hi > n)
					break;
			end else if (win > target_mirror) begin
				lo++;
			end else begin
				break;  // exact match ends the walk
			end
		end
		w.start_idx = idx_t'(best_lo - 1);
		w.end_idx   = idx_t'(best_hi - 1);
		return w;
	endfunction

	// One accepted element. A full store drops the element, but a dropped
	// last element still triggers the search.
	function automatic void absorb_element(input val_t v, input logic fin);
		if (elem_cnt < MAX_ITEMS) begin
			run_total          = run_total + sum_t'(v);
			prefix_mem[elem_cnt] = run_total;
			elem_cnt++;
		end
		if (fin) begin
			window_q.push_back(closest_window());
			run_total = '0;
			elem_cnt  = 0;
		end
	endfunction

	// Element driver: a new transaction is offered only once the last one has
	// gone, so valid never drops while an offered element is still untaken.
	always @(negedge clk) begin : elem_drive
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || item_taken) begin
			if (elem_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_value <= elem_q[0].value;
				in_last  <= elem_q[0].ends_set;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result ready: random stalls, plus a long hold-off on request that is
	// counted down here.
	always @(negedge clk) begin : res_pace
		int hold_left;
		int hold_seen;
		if (!arst_n) begin
			res_rdy   <= 1'b0;
			hold_left = 0;
			hold_seen = 0;
		end else if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
			res_rdy   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			res_rdy <= 1'b0;
		end else begin
			res_rdy <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: outputs change on the clock edge, so what is read here is the
	// value from before the edge.
	always @(posedge clk) begin : watch
		window_t want;
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= in_valid && in_ch.ready;
			if (in_valid && in_ch.ready) begin
				void'(elem_q.pop_front());
				absorb_element(in_value, in_last);
			end
			if (res_ch.valid && res_rdy) begin
				if (window_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result with none expected, start %0d end %0d",
						$time, res_ch.window_start, res_ch.window_end);
				end else begin
					want = window_q.pop_front();
					if (res_ch.window_start !== want.start_idx) begin
						err_cnt++;
						$display("%0t: window_start expected %0d got %0d",
							$time, want.start_idx, res_ch.window_start);
					end
					if (res_ch.window_end !== want.end_idx) begin
						err_cnt++;
						$display("%0t: window_end expected %0d got %0d",
							$time, want.end_idx, res_ch.window_end);
					end
				end
			end
		end
	end

	task automatic push_elem(input val_t v, input logic fin);
		elem_t e;
		e.value    = v;
		e.ends_set = fin;
		elem_q.push_back(e);
	endtask

	// One set of len elements; values lean on both ends of 0..vmax.
	task automatic queue_set(input int len, input int vmax);
		int   i;
		int   pick;
		val_t v;
		for (i = 0; i < len; i++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				v = '0;
			else if (pick == 1)
				v = val_t'(vmax);
			else
				v = val_t'($urandom_range(0, vmax));
			push_elem(v, i == len - 1);
		end
	endtask

	// Block is idle once every element has gone and every window is in.
	task automatic wait_idle();
		while (elem_q.size() != 0 || window_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(input sum_t t);
		wait_idle();
		@(negedge clk);
		cfg_valid  <= 1'b1;
		cfg_target <= t;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		target_mirror = t;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int   ph;
		int   cnt;
		int   len;
		int   vmax;
		sum_t tgt;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 27;
		recv_idle_pct = 47;

		// Directed sets. Target is still at its reset value of zero here.
		push_elem(16'd0, 1'b1);                 // single zero, exact at once
		push_elem(16'd5, 1'b0);                 // left end overtakes the right:
		push_elem(16'd0, 1'b0);                 // empty window, then exact zero
		push_elem(16'd3, 1'b1);

		write_target(SUM_MAX);                  // never reached, right end runs out
		push_elem(16'hFFFF, 1'b0);
		push_elem(16'hFFFF, 1'b0);
		push_elem(16'd1, 1'b1);

		write_target(sum_t'(10));               // tie between 5 and 15: first kept
		push_elem(16'd5, 1'b0);
		push_elem(16'd15, 1'b1);

		write_target(sum_t'(100));              // exact match stops the walk early
		push_elem(16'd30, 1'b0);
		push_elem(16'd70, 1'b0);
		push_elem(16'd100, 1'b0);
		push_elem(16'd50, 1'b0);
		push_elem(16'd50, 1'b0);
		push_elem(16'd1, 1'b1);
		push_elem(16'd1, 1'b1);

		// Random phases: idling sender-light, then receiver-light, then none.
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				tgt  = SUM_MAX;
				vmax = 65535;
			end else if (ph == 1) begin
				tgt  = '0;
				vmax = 3;
			end else begin
				case ($urandom_range(0, 3))
					0: vmax = 1;
					1: vmax = 15;
					2: vmax = 255;
					default: vmax = 65535;
				endcase
				if (ph == BIG_PHASE || $urandom_range(0, 3) == 0)
					tgt = sum_t'($urandom_range(0, 32'h3FF_FFFF));
				else
					tgt = sum_t'($urandom_range(0, vmax * 8));
			end
			write_target(tgt);

			if (ph < 8) begin
				send_idle_pct = 27;
				recv_idle_pct = 47;
			end else if (ph < 16) begin
				send_idle_pct = 47;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			if (ph == BIG_PHASE) begin
				// Overfills the store: the trailing elements, last one included,
				// are dropped but the search still runs.
				queue_set(BIG_LEN, 65535);
			end else begin
				// Result held off while short sets keep coming, so the block
				// fills up and stalls its input.
				if (ph == HOLD_PHASE)
					hold_asks = hold_asks + 1;
				cnt = 0;
				while (cnt < PHASE_ITEMS) begin
					if (ph == HOLD_PHASE)
						len = $urandom_range(1, 4);
					else if ($urandom_range(0, 7) == 0)
						len = $urandom_range(9, 40);
					else
						len = $urandom_range(1, 8);
					queue_set(len, vmax);
					cnt += len;
				end
			end
		end

		wait_idle();
		if (err_cnt == 0 && window_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Run limit: far beyond the slowest correct run.
	initial begin : run_limit
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

### closest_window_sum_search.f
rtl/cwss_pkg.sv
rtl/cwss_if.sv
rtl/closest_window_sum_search.sv
verif/tb_closest_window_sum_search.sv
